// File: hdl/tae_pkg.sv
// Shared types and constants for the Thumb ALU execute block.
package tae_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned AMT_W   = 8;
	localparam int unsigned SHAMT_W = $clog2(DATA_W);

	localparam logic [AMT_W-1:0] SHIFT_FULL = AMT_W'(DATA_W);

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_LSL = 4'd2,
		OP_LSR = 4'd3,
		OP_ASR = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_ROR = 4'd7,
		OP_TST = 4'd8,
		OP_NEG = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MUL = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} tae_op_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} tae_shift_t;

	typedef struct packed {
		tae_op_t           op;
		logic [DATA_W-1:0] rs_value;
		logic [DATA_W-1:0] rd_value;
		logic              carry_in;
		logic              overflow_in;
	} tae_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              write_back;
		logic              flag_n;
		logic              flag_z;
		logic              flag_c;
		logic              flag_v;
	} tae_rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              carry;
	} tae_shift_res_t;

endpackage

// File: hdl/tae_if.sv
// Valid/ready channel interfaces for operations and results.
interface tae_cmd_if import tae_pkg::*; ();
	logic     valid;
	logic     ready;
	tae_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tae_rsp_if import tae_pkg::*; ();
	logic     valid;
	logic     ready;
	tae_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/tae_shifter.sv
// Barrel shifter for LSL, LSR, ASR and ROR with Thumb carry rules.
module tae_shifter import tae_pkg::*; (
	input  logic [DATA_W-1:0] rd,
	input  logic [AMT_W-1:0]  amt,
	input  tae_shift_t        kind,
	input  logic              carry_in,
	output tae_shift_res_t    res
);

	logic [DATA_W:0]     lsl_w;
	logic [DATA_W:0]     lsr_w;
	logic [DATA_W:0]     asr_w;
	logic [2*DATA_W-1:0] ror_w;
	logic                big;
	logic                exact;

	always_comb begin
		lsl_w = {1'b0, rd} << amt[SHAMT_W-1:0];
		lsr_w = {rd, 1'b0} >> amt[SHAMT_W-1:0];
		asr_w = $signed({rd, 1'b0}) >>> amt[SHAMT_W-1:0];
		ror_w = {rd, rd} >> amt[SHAMT_W-1:0];
		big   = |amt[AMT_W-1:SHAMT_W];
		exact = (amt == SHIFT_FULL);

		res.value = rd;
		res.carry = carry_in;
		if (amt != '0) begin
			unique case (kind)
				SH_LSL: begin
					if (!big) begin
						res.value = lsl_w[DATA_W-1:0];
						res.carry = lsl_w[DATA_W];
					end else begin
						res.value = '0;
						res.carry = exact & rd[0];
					end
				end
				SH_LSR: begin
					if (!big) begin
						res.value = lsr_w[DATA_W:1];
						res.carry = lsr_w[0];
					end else begin
						res.value = '0;
						res.carry = exact & rd[DATA_W-1];
					end
				end
				SH_ASR: begin
					if (!big) begin
						res.value = asr_w[DATA_W:1];
						res.carry = asr_w[0];
					end else begin
						res.value = {DATA_W{rd[DATA_W-1]}};
						res.carry = rd[DATA_W-1];
					end
				end
				SH_ROR: begin
					res.value = ror_w[DATA_W-1:0];
					res.carry = ror_w[DATA_W-1];
				end
				default: begin
					res.value = rd;
					res.carry = carry_in;
				end
			endcase
		end
	end

endmodule

// File: hdl/thumb_alu_execute.sv
// Thumb register ALU execute unit: input register, ALU, result register.
//
//   channel  dir  payload                                     handshake
//   cmd      in   op, rs_value, rd_value, carry_in,           valid/ready
//                 overflow_in
//   rsp      out  result, write_back, flag_n, flag_z,         valid/ready
//                 flag_c, flag_v
//
// One transaction per cycle sustained while rsp is not stalled; an accepted command
// passes through the input register and the result register before it is offered.
// The ALU between them has the 32x32 multiplier as its longest path.
// arst_n clears both valid bits; payload registers are not reset.
// A stalled result holds the result register, then the input register, then cmd.
module thumb_alu_execute import tae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tae_cmd_if.sink    cmd,
	tae_rsp_if.source  rsp
);

	logic           valid_s1;
	tae_cmd_t       cmd_s1;
	logic           valid_s2;
	tae_rsp_t       rsp_s2;
	logic           adv_s2;
	logic           adv_s1;
	tae_shift_t     shift_kind;
	tae_shift_res_t shift_res;
	logic [DATA_W-1:0] add_a;
	logic [DATA_W-1:0] add_b;
	logic              add_cin;
	logic [DATA_W:0]   add_sum;
	logic              add_v;
	logic [DATA_W-1:0] prod;
	tae_rsp_t          rsp_d;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;
	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && adv_s1) begin
			cmd_s1 <= cmd.data;
		end
		if (valid_s1 && adv_s2) begin
			rsp_s2 <= rsp_d;
		end
	end

	always_comb begin
		unique case (cmd_s1.op)
			OP_LSR:  shift_kind = SH_LSR;
			OP_ASR:  shift_kind = SH_ASR;
			OP_ROR:  shift_kind = SH_ROR;
			default: shift_kind = SH_LSL;
		endcase
	end

	tae_shifter u_shifter (
		.rd       (cmd_s1.rd_value),
		.amt      (cmd_s1.rs_value[AMT_W-1:0]),
		.kind     (shift_kind),
		.carry_in (cmd_s1.carry_in),
		.res      (shift_res)
	);

	always_comb begin
		unique case (cmd_s1.op)
			OP_ADC: begin
				add_a   = cmd_s1.rd_value;
				add_b   = cmd_s1.rs_value;
				add_cin = cmd_s1.carry_in;
			end
			OP_SBC: begin
				add_a   = cmd_s1.rd_value;
				add_b   = ~cmd_s1.rs_value;
				add_cin = cmd_s1.carry_in;
			end
			OP_NEG: begin
				add_a   = '0;
				add_b   = ~cmd_s1.rs_value;
				add_cin = 1'b1;
			end
			OP_CMP: begin
				add_a   = cmd_s1.rd_value;
				add_b   = ~cmd_s1.rs_value;
				add_cin = 1'b1;
			end
			default: begin
				add_a   = cmd_s1.rd_value;
				add_b   = cmd_s1.rs_value;
				add_cin = 1'b0;
			end
		endcase
		add_sum = {1'b0, add_a} + {1'b0, add_b} + (DATA_W+1)'(add_cin);
		add_v   = ~(add_a[DATA_W-1] ^ add_b[DATA_W-1])
			& (add_a[DATA_W-1] ^ add_sum[DATA_W-1]);
		prod    = cmd_s1.rd_value * cmd_s1.rs_value;
	end

	always_comb begin
		rsp_d.write_back = 1'b1;
		rsp_d.flag_c     = cmd_s1.carry_in;
		rsp_d.flag_v     = cmd_s1.overflow_in;
		unique case (cmd_s1.op)
			OP_AND: rsp_d.result = cmd_s1.rd_value & cmd_s1.rs_value;
			OP_EOR: rsp_d.result = cmd_s1.rd_value ^ cmd_s1.rs_value;
			OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
				rsp_d.result = shift_res.value;
				rsp_d.flag_c = shift_res.carry;
			end
			OP_ADC, OP_SBC, OP_NEG: begin
				rsp_d.result = add_sum[DATA_W-1:0];
				rsp_d.flag_c = add_sum[DATA_W];
				rsp_d.flag_v = add_v;
			end
			OP_CMP, OP_CMN: begin
				rsp_d.result     = add_sum[DATA_W-1:0];
				rsp_d.flag_c     = add_sum[DATA_W];
				rsp_d.flag_v     = add_v;
				rsp_d.write_back = 1'b0;
			end
			OP_TST: begin
				rsp_d.result     = cmd_s1.rd_value & cmd_s1.rs_value;
				rsp_d.write_back = 1'b0;
			end
			OP_ORR: rsp_d.result = cmd_s1.rd_value | cmd_s1.rs_value;
			OP_MUL: rsp_d.result = prod;
			OP_BIC: rsp_d.result = cmd_s1.rd_value & ~cmd_s1.rs_value;
			OP_MVN: rsp_d.result = ~cmd_s1.rs_value;
			default: rsp_d.result = ~cmd_s1.rs_value;
		endcase
		rsp_d.flag_n = rsp_d.result[DATA_W-1];
		rsp_d.flag_z = (rsp_d.result == '0);
	end

endmodule

// File: hdl/tae_checker.sv
// Port-level checks for the Thumb ALU execute unit, bound to the top level.
module tae_checker import tae_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input tae_cmd_t cmd_data,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input tae_rsp_t rsp_data
);

	logic [1:0] inflight_q;
	logic       cmd_fire;
	logic       rsp_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(cmd_fire) - 2'(rsp_fire);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != 2'd0)
		else $error("result without an accepted transaction");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd0 |-> cmd_ready)
		else $error("empty unit refused a transaction");

	a_latency_wb: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && inflight_q == 2'd0 |-> ##2 rsp_valid
			&& rsp_data.write_back == !($past(cmd_data.op, 2) == OP_TST
			|| $past(cmd_data.op, 2) == OP_CMP || $past(cmd_data.op, 2) == OP_CMN))
		else $error("result late or write-back wrong");

	a_nz_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.flag_n == rsp_data.result[DATA_W-1]
			&& rsp_data.flag_z == (rsp_data.result == '0))
		else $error("N or Z flag disagrees with result");

endmodule

bind thumb_alu_execute tae_checker u_tae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_data  (cmd.data),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
